// File: design/stok_pkg.sv
// Shared types, codes and operator table for the source tokenizer stream.
package stok_pkg;

    localparam int unsigned NUM_OPS = 39;
    localparam int unsigned MAX_RES = 3;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_STRING = 3'd3,
        MODE_OPER   = 3'd4
    } lex_mode_t;

    typedef enum logic [1:0] {
        EV_BEGIN = 2'd0,
        EV_TEXT  = 2'd1,
        EV_END   = 2'd2,
        EV_OPER  = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        KIND_IDENT  = 2'd0,
        KIND_NUMBER = 2'd1,
        KIND_STRING = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_UNKNOWN_OPER = 2'd1,
        ERR_OPEN_STRING  = 2'd2
    } err_t;

    localparam logic [5:0] OP_NONE = 6'(NUM_OPS);
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // One result item
    typedef struct packed {
        logic [1:0] event_res;
        logic [1:0] token_kind;
        logic [7:0] text_byte;
        logic [5:0] operator_code;
        logic [1:0] error_code;
    } res_t;

    // Lexer state carried between requests
    typedef struct packed {
        lex_mode_t  mode;
        logic [7:0] pend;
        logic       bs;
    } lex_state_t;

    // Decoder outcome for one request
    typedef struct packed {
        res_t [MAX_RES-1:0] res;
        logic [1:0]         cnt;
        lex_state_t         nxt;
    } dec_t;

    // Operator list: first char, second char (zero for one-char operators)
    localparam logic [15:0] OP_TABLE [0:NUM_OPS-1] = '{
        {"+", 8'h00}, "+=", "++", {"-", 8'h00}, "-=", "--", {"*", 8'h00}, "*=",
        "**", {"/", 8'h00}, "/=", {"%", 8'h00}, "%=", {"=", 8'h00}, "==",
        {">", 8'h00}, ">=", ">>", {"<", 8'h00}, "<=", "<<", {"&", 8'h00}, "&&",
        {"|", 8'h00}, "||", {"^", 8'h00}, "^^", {"~", 8'h00}, {"!", 8'h00},
        "!=", "..", {"@", 8'h00}, {"?", 8'h00}, {":", 8'h00}, {"(", 8'h00},
        {")", 8'h00}, {"[", 8'h00}, {"]", 8'h00}, {",", 8'h00}
    };

    function automatic res_t make_res(event_t ev, kind_t kind, logic [7:0] ch,
                                      logic [5:0] op, err_t err);
        res_t r;
        r.event_res     = ev;
        r.token_kind    = kind;
        r.text_byte     = ch;
        r.operator_code = op;
        r.error_code    = err;
        return r;
    endfunction

    // First matching operator index, OP_NONE when nothing matches
    function automatic logic [5:0] find_op(logic [7:0] c1, logic [7:0] c2);
        logic [5:0] idx;
        idx = OP_NONE;
        for (int i = NUM_OPS - 1; i >= 0; i--) begin
            if (OP_TABLE[i] == {c1, c2}) begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic is_op_start(logic [7:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_OPS; i++) begin
            if (OP_TABLE[i][15:8] == c) begin
                hit = 1'b1;
            end
        end
        return hit && (c != 8'h00);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Held operator char reported alone (lone dot is the unknown case)
    function automatic res_t single_op(logic [7:0] c);
        logic [5:0] idx;
        idx = find_op(c, 8'h00);
        if (idx == OP_NONE) begin
            return make_res(EV_OPER, KIND_IDENT, 8'h00, 6'd0, ERR_UNKNOWN_OPER);
        end
        return make_res(EV_OPER, KIND_IDENT, 8'h00, idx, ERR_NONE);
    endfunction

endpackage

// File: design/stok_if.sv
// Stream interfaces for source bytes in and token events out.
interface stok_feed_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] symbol;

    modport source (output valid, action, symbol, input ready);
    modport sink (input valid, action, symbol, output ready);
endinterface

interface stok_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [1:0] token_kind;
    logic [7:0] text_byte;
    logic [5:0] operator_code;
    logic [1:0] error_code;
    logic       run_last;

    modport source (output valid, event_res, token_kind, text_byte, operator_code,
                    error_code, run_last, input ready);
    modport sink (input valid, event_res, token_kind, text_byte, operator_code,
                  error_code, run_last, output ready);
endinterface

// File: design/stok_decode.sv
// Per-request lexer decision: result list and next lexer state.
module stok_decode (
    input  stok_pkg::lex_state_t st,
    input  logic                 action,
    input  logic [7:0]           symbol,
    output stok_pkg::dec_t       dec
);

    logic                 pre_vld;
    stok_pkg::res_t       pre;
    logic                 use_start;
    logic [1:0]           s_cnt;
    stok_pkg::res_t       s0;
    stok_pkg::res_t       s1;
    stok_pkg::lex_mode_t  s_mode;
    logic [5:0]           pair_idx;
    stok_pkg::res_t       res_zero;
    stok_pkg::lex_state_t nxt;

    assign res_zero = '0;
    assign pair_idx = (symbol != 8'h00) ? stok_pkg::find_op(st.pend, symbol)
                                        : stok_pkg::OP_NONE;

    // Token start from an idle lexer
    always_comb
    begin
        s_cnt  = 2'd0;
        s0     = res_zero;
        s1     = res_zero;
        s_mode = stok_pkg::MODE_IDLE;
        priority if (symbol == stok_pkg::CH_QUOTE)
        begin
            s_cnt  = 2'd1;
            s0     = stok_pkg::make_res(stok_pkg::EV_BEGIN, stok_pkg::KIND_STRING,
                                        8'h00, 6'd0, stok_pkg::ERR_NONE);
            s_mode = stok_pkg::MODE_STRING;
        end
        else if (stok_pkg::is_digit(symbol))
        begin
            s_cnt  = 2'd2;
            s0     = stok_pkg::make_res(stok_pkg::EV_BEGIN, stok_pkg::KIND_NUMBER,
                                        8'h00, 6'd0, stok_pkg::ERR_NONE);
            s1     = stok_pkg::make_res(stok_pkg::EV_TEXT, stok_pkg::KIND_NUMBER,
                                        symbol, 6'd0, stok_pkg::ERR_NONE);
            s_mode = stok_pkg::MODE_NUMBER;
        end
        else if (stok_pkg::is_op_start(symbol))
        begin
            s_mode = stok_pkg::MODE_OPER;
        end
        else if (stok_pkg::is_letter(symbol))
        begin
            s_cnt  = 2'd2;
            s0     = stok_pkg::make_res(stok_pkg::EV_BEGIN, stok_pkg::KIND_IDENT,
                                        8'h00, 6'd0, stok_pkg::ERR_NONE);
            s1     = stok_pkg::make_res(stok_pkg::EV_TEXT, stok_pkg::KIND_IDENT,
                                        symbol, 6'd0, stok_pkg::ERR_NONE);
            s_mode = stok_pkg::MODE_IDENT;
        end
        else
        begin
            s_mode = stok_pkg::MODE_IDLE;
        end
    end

    // Mode decision: optional leading result, optional token start
    always_comb
    begin
        pre_vld   = 1'b0;
        pre       = res_zero;
        use_start = 1'b0;
        nxt       = st;
        if (action)
        begin
            unique case (st.mode)
                stok_pkg::MODE_IDENT:
                begin
                    pre_vld = 1'b1;
                    pre = stok_pkg::make_res(stok_pkg::EV_END, stok_pkg::KIND_IDENT,
                                             8'h00, 6'd0, stok_pkg::ERR_NONE);
                end
                stok_pkg::MODE_NUMBER:
                begin
                    pre_vld = 1'b1;
                    pre = stok_pkg::make_res(stok_pkg::EV_END, stok_pkg::KIND_NUMBER,
                                             8'h00, 6'd0, stok_pkg::ERR_NONE);
                end
                stok_pkg::MODE_STRING:
                begin
                    pre_vld = 1'b1;
                    pre = stok_pkg::make_res(stok_pkg::EV_END, stok_pkg::KIND_STRING,
                                             8'h00, 6'd0, stok_pkg::ERR_OPEN_STRING);
                end
                stok_pkg::MODE_OPER:
                begin
                    pre_vld = 1'b1;
                    pre = stok_pkg::single_op(st.pend);
                end
                default:
                begin
                    pre_vld = 1'b0;
                end
            endcase
            nxt.mode = stok_pkg::MODE_IDLE;
            nxt.pend = 8'h00;
            nxt.bs   = 1'b0;
        end
        else
        begin
            unique case (st.mode)
                stok_pkg::MODE_IDENT:
                begin
                    pre_vld = 1'b1;
                    if (stok_pkg::is_letter(symbol) || stok_pkg::is_digit(symbol))
                    begin
                        pre = stok_pkg::make_res(stok_pkg::EV_TEXT, stok_pkg::KIND_IDENT,
                                                 symbol, 6'd0, stok_pkg::ERR_NONE);
                    end
                    else
                    begin
                        pre = stok_pkg::make_res(stok_pkg::EV_END, stok_pkg::KIND_IDENT,
                                                 8'h00, 6'd0, stok_pkg::ERR_NONE);
                        use_start = 1'b1;
                    end
                end
                stok_pkg::MODE_NUMBER:
                begin
                    pre_vld = 1'b1;
                    if (stok_pkg::is_digit(symbol))
                    begin
                        pre = stok_pkg::make_res(stok_pkg::EV_TEXT, stok_pkg::KIND_NUMBER,
                                                 symbol, 6'd0, stok_pkg::ERR_NONE);
                    end
                    else
                    begin
                        pre = stok_pkg::make_res(stok_pkg::EV_END, stok_pkg::KIND_NUMBER,
                                                 8'h00, 6'd0, stok_pkg::ERR_NONE);
                        use_start = 1'b1;
                    end
                end
                stok_pkg::MODE_STRING:
                begin
                    pre_vld = 1'b1;
                    if (symbol == stok_pkg::CH_QUOTE && !st.bs)
                    begin
                        pre = stok_pkg::make_res(stok_pkg::EV_END, stok_pkg::KIND_STRING,
                                                 8'h00, 6'd0, stok_pkg::ERR_NONE);
                        nxt.mode = stok_pkg::MODE_IDLE;
                        nxt.bs   = 1'b0;
                    end
                    else
                    begin
                        pre = stok_pkg::make_res(stok_pkg::EV_TEXT, stok_pkg::KIND_STRING,
                                                 symbol, 6'd0, stok_pkg::ERR_NONE);
                        nxt.bs = (symbol == stok_pkg::CH_BSLASH);
                    end
                end
                stok_pkg::MODE_OPER:
                begin
                    pre_vld = 1'b1;
                    if (pair_idx != stok_pkg::OP_NONE)
                    begin
                        pre = stok_pkg::make_res(stok_pkg::EV_OPER, stok_pkg::KIND_IDENT,
                                                 8'h00, pair_idx, stok_pkg::ERR_NONE);
                        nxt.mode = stok_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        pre = stok_pkg::single_op(st.pend);
                        use_start = 1'b1;
                    end
                end
                default:
                begin
                    use_start = 1'b1;
                end
            endcase
            // Token start updates mode, held operator char and escape flag
            if (use_start)
            begin
                nxt.mode = s_mode;
                if (s_mode == stok_pkg::MODE_OPER)
                begin
                    nxt.pend = symbol;
                end
                if (s_mode == stok_pkg::MODE_STRING)
                begin
                    nxt.bs = 1'b0;
                end
            end
            if (st.mode == stok_pkg::MODE_OPER && nxt.mode != stok_pkg::MODE_OPER)
            begin
                nxt.pend = 8'h00;
            end
        end
    end

    // Pack the leading result ahead of the start results
    always_comb
    begin
        dec.res = '0;
        dec.cnt = 2'd0;
        dec.nxt = nxt;
        if (pre_vld)
        begin
            dec.res[0] = pre;
            if (use_start)
            begin
                dec.res[1] = s0;
                dec.res[2] = s1;
                dec.cnt    = 2'd1 + s_cnt;
            end
            else
            begin
                dec.cnt = 2'd1;
            end
        end
        else if (use_start)
        begin
            dec.res[0] = s0;
            dec.res[1] = s1;
            dec.cnt    = s_cnt;
        end
    end

endmodule

// File: design/stok_queue.sv
// Result register bank: holds one request's results and sends them one a cycle while emit.ready is high.
module stok_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  stok_pkg::dec_t       dec,
    output logic                 can_push,
    stok_event_if.source         emit
);

    stok_pkg::res_t [stok_pkg::MAX_RES-1:0] ent_reg;
    logic [1:0]     cnt_reg;
    logic [1:0]     ptr_reg;
    logic [1:0]     cnt_next;
    logic [1:0]     ptr_next;
    logic           empty;
    logic           last;
    logic           pop;
    stok_pkg::res_t head;

    assign empty    = (ptr_reg == cnt_reg);
    assign last     = (ptr_reg == cnt_reg - 2'd1);
    assign pop      = !empty && emit.ready;
    assign can_push = empty || (pop && last);

    // Head entry select
    always_comb
    begin
        unique case (ptr_reg)
            2'd0:    head = ent_reg[0];
            2'd1:    head = ent_reg[1];
            2'd2:    head = ent_reg[2];
            default: head = '0;
        endcase
    end

    assign emit.valid         = !empty;
    assign emit.event_res     = head.event_res;
    assign emit.token_kind    = head.token_kind;
    assign emit.text_byte     = head.text_byte;
    assign emit.operator_code = head.operator_code;
    assign emit.error_code    = head.error_code;
    assign emit.run_last      = last;

    // Read pointer and fill count
    always_comb
    begin
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (push)
        begin
            cnt_next = dec.cnt;
            ptr_next = 2'd0;
        end
        else if (pop)
        begin
            ptr_next = ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            ptr_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg <= dec.res;
        end
    end

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= cnt_reg)
        else $error("read pointer past fill count");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(stok_pkg::MAX_RES))
        else $error("fill count above result limit");

    a_keep_group: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !last) |=> emit.valid)
        else $error("result group cut short");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (push && dec.cnt != 2'd0) |=> (emit.valid && ptr_reg == 2'd0))
        else $error("loaded results not presented");

endmodule

// File: design/source_tokenizer_stream_core.sv
// Top level of the source tokenizer stream: lexer state, decoder and result bank.
//
// Usage:
//   feed carries one source byte per request (action 0) or an end-of-input
//   request (action 1). emit carries token events: begin, text character,
//   end, or operator code, with run_last marking the final event of a request.
//   A request gives zero to three events.
// Latency: events of a request appear the cycle after it is accepted.
// Throughput: one request per cycle while each gives at most one event and
//   emit.ready stays high; a request giving several events holds the result
//   bank, and the next request is taken in the same cycle its last event is
//   taken. A request giving no event leaves the bank empty, so the
//   next request is taken on the following cycle.
// Stall: when emit.ready is low the held event stays put; feed.ready is low
//   whenever the bank holds an event, except in the cycle its last event is
//   taken.
// Reset: rst_n clears the lexer to idle with no held operator and empties
//   the result bank.
module source_tokenizer_stream_core (
    input  logic         clk,
    input  logic         rst_n,
    stok_feed_if.sink    feed,
    stok_event_if.source emit
);

    stok_pkg::lex_state_t st_reg;
    stok_pkg::lex_state_t st_next;
    stok_pkg::dec_t       dec;
    logic                 can_push;
    logic                 push;

    assign feed.ready = can_push;
    assign push       = feed.valid && can_push;

    stok_decode u_decode (
        .st     (st_reg),
        .action (feed.action),
        .symbol (feed.symbol),
        .dec    (dec)
    );

    stok_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .dec      (dec),
        .can_push (can_push),
        .emit     (emit)
    );

    // Lexer state advances on each accepted request
    assign st_next = push ? dec.nxt : st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode <= stok_pkg::MODE_IDLE;
            st_reg.pend <= 8'h00;
            st_reg.bs   <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    a_pend_oper: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.mode != stok_pkg::MODE_OPER) |-> (st_reg.pend == 8'h00))
        else $error("held operator char outside operator mode");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push && feed.action) |=> (st_reg.mode == stok_pkg::MODE_IDLE))
        else $error("lexer not idle after end of input");

    a_oper_held: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.mode == stok_pkg::MODE_OPER) |-> stok_pkg::is_op_start(st_reg.pend))
        else $error("held char starts no operator");

endmodule
